// ===== rtl/scl_pkg.sv =====
// scl_pkg: shared types, character codes and helpers for the script command lexer
// used by scl_step and script_command_lexer_core; no dependencies
package scl_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // results one character can cause, and the width of a count of them
  localparam int MaxRes  = 3;
  localparam int ResCntW = $clog2(MaxRes + 1);

  typedef enum logic [1:0] {
    LP_START,
    LP_LINE,
    LP_SKIP
  } line_phase_t;

  typedef enum logic [1:0] {
    TP_BETWEEN,
    TP_PLAIN,
    TP_QUOTED
  } token_phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_START,
    KIND_END
  } kind_t;

  typedef struct packed {
    logic         held_slash;
    logic         held_token_start;
    line_phase_t  line_phase;
    logic         quote_parity;
    token_phase_t token_phase;
    logic         line_has_token;
  } lex_state_t;

  localparam lex_state_t LexReset = '{
    held_slash:       1'b0,
    held_token_start: 1'b0,
    line_phase:       LP_START,
    quote_parity:     1'b0,
    token_phase:      TP_BETWEEN,
    line_has_token:   1'b0
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       ok;
  } lex_res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_SPACE) || (c == CH_NL) || (c == CH_CR);
  endfunction

endpackage

// ===== rtl/scl_step.sv =====
// scl_step: combinational next state and result list for one script character
// depends on scl_pkg
module scl_step
  import scl_pkg::*;
(
  input  lex_state_t                 state_i,
  input  logic [7:0]                 char_i,
  input  logic                       end_i,
  output lex_state_t                 state_o,
  output lex_res_t [MaxRes-1:0]      res_o,
  output logic [ResCntW-1:0]         cnt_o
);

  lex_state_t            st;
  lex_res_t [MaxRes-1:0] r;
  logic [ResCntW-1:0]    n;

  always_comb begin
    st = state_i;
    r  = '0;
    n  = '0;
    if (end_i) begin
      // a lone held slash becomes an ordinary byte before the line closes
      if (st.held_slash) begin
        if (st.held_token_start) begin
          r[n] = '{kind: KIND_START, ch: 8'h00, ok: 1'b0};
          n = n + ResCntW'(1);
          st.line_has_token = 1'b1;
          st.token_phase    = TP_PLAIN;
        end
        r[n] = '{kind: KIND_CHAR, ch: CH_SLASH, ok: 1'b0};
        n = n + ResCntW'(1);
        st.line_phase = LP_LINE;
      end
      if (st.line_phase != LP_SKIP && st.line_has_token) begin
        r[n] = '{kind: KIND_END, ch: 8'h00, ok: (st.token_phase != TP_QUOTED)};
        n = n + ResCntW'(1);
      end
      st = LexReset;
    end else if (st.line_phase == LP_SKIP) begin
      if (char_i == CH_NL) begin
        st.line_phase = LP_START;
      end
    end else if (st.held_slash && char_i == CH_SLASH) begin
      // double slash: close the line and skip to newline
      if (st.line_has_token) begin
        r[n] = '{kind: KIND_END, ch: 8'h00, ok: (st.token_phase != TP_QUOTED)};
        n = n + ResCntW'(1);
      end
      st = LexReset;
      st.line_phase = LP_SKIP;
    end else begin
      if (st.held_slash) begin
        if (st.held_token_start) begin
          r[n] = '{kind: KIND_START, ch: 8'h00, ok: 1'b0};
          n = n + ResCntW'(1);
          st.line_has_token = 1'b1;
          st.token_phase    = TP_PLAIN;
        end
        r[n] = '{kind: KIND_CHAR, ch: CH_SLASH, ok: 1'b0};
        n = n + ResCntW'(1);
        st.held_slash       = 1'b0;
        st.held_token_start = 1'b0;
        st.line_phase       = LP_LINE;
      end
      if (char_i == CH_SLASH) begin
        st.held_slash       = 1'b1;
        st.held_token_start = (st.token_phase == TP_BETWEEN);
      end else begin
        st.quote_parity = st.quote_parity ^ (char_i == CH_QUOTE);
        if (char_i == CH_NL || (char_i == CH_SEMI && !st.quote_parity)) begin
          if (st.line_has_token) begin
            r[n] = '{kind: KIND_END, ch: 8'h00, ok: (st.token_phase != TP_QUOTED)};
            n = n + ResCntW'(1);
          end
          st.quote_parity   = 1'b0;
          st.token_phase    = TP_BETWEEN;
          st.line_has_token = 1'b0;
          st.line_phase     = LP_START;
        end else begin
          if (!(st.line_phase == LP_START && (char_i == CH_SPACE || char_i == CH_TAB))) begin
            st.line_phase = LP_LINE;
          end
          case (st.token_phase)
            TP_BETWEEN: begin
              if (!is_blank(char_i)) begin
                r[n] = '{kind: KIND_START, ch: 8'h00, ok: 1'b0};
                n = n + ResCntW'(1);
                st.line_has_token = 1'b1;
                if (char_i == CH_QUOTE) begin
                  st.token_phase = TP_QUOTED;
                end else begin
                  r[n] = '{kind: KIND_CHAR, ch: char_i, ok: 1'b0};
                  n = n + ResCntW'(1);
                  st.token_phase = TP_PLAIN;
                end
              end
            end
            TP_PLAIN: begin
              if (is_blank(char_i)) begin
                st.token_phase = TP_BETWEEN;
              end else begin
                r[n] = '{kind: KIND_CHAR, ch: char_i, ok: 1'b0};
                n = n + ResCntW'(1);
              end
            end
            default: begin
              if (char_i == CH_QUOTE) begin
                st.token_phase = TP_BETWEEN;
              end else begin
                r[n] = '{kind: KIND_CHAR, ch: char_i, ok: 1'b0};
                n = n + ResCntW'(1);
              end
            end
          endcase
        end
      end
    end
  end

  assign state_o = st;
  assign res_o   = r;
  assign cnt_o   = n;

endmodule

// ===== rtl/script_command_lexer_core.sv =====
// script_command_lexer_core: input register, lexer step and a three-entry result queue
// depends on scl_pkg and scl_step
// a taken character waits in the input register until the queue takes its results
// throughput: one character per cycle while out_tready is high and each gives at most
//   one result; more results hold the input until the single output port drains them
// reset: synchronous active-low rst_n clears the lexer state, the input register and queue
module script_command_lexer_core
  import scl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tlast,   // end_mark
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_char, [8] line_ok, rest zero
  output logic [1:0]  out_tuser   // [1:0] kind
);

  logic                  in_valid_r;
  logic [7:0]            in_char_r;
  logic                  in_end_r;
  lex_state_t            state_r;
  lex_state_t            state_nxt;
  lex_res_t [MaxRes-1:0] res_r;
  lex_res_t [MaxRes-1:0] step_res;
  logic [ResCntW-1:0]    cnt_r;
  logic [ResCntW-1:0]    step_cnt;
  logic                  out_fire;
  logic                  load;

  scl_step u_step (
    .state_i (state_r),
    .char_i  (in_char_r),
    .end_i   (in_end_r),
    .state_o (state_nxt),
    .res_o   (step_res),
    .cnt_o   (step_cnt)
  );

  assign out_fire  = out_tvalid && out_tready;
  // queue takes a new batch once it is empty or its last entry leaves now
  assign load      = in_valid_r &&
                     ((cnt_r == '0) || (cnt_r == ResCntW'(1) && out_fire));
  assign in_tready = !in_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (load) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LexReset;
      cnt_r   <= '0;
    end else if (load) begin
      state_r <= state_nxt;
      cnt_r   <= step_cnt;
    end else if (out_fire) begin
      cnt_r   <= cnt_r - ResCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= step_res;
    end else if (out_fire) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {7'b0, res_r[0].ok, res_r[0].ch};
  assign out_tuser  = res_r[0].kind;

  // queue never holds more than one character's results
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ResCntW'(MaxRes))
    else $error("result queue count out of range");

  // line ends and argument starts carry no character
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_END || out_tuser == KIND_START))
      |-> (out_tdata[7:0] == 8'h00))
    else $error("non-character result carries a byte");

  // the end mark returns the lexer to its reset state
  assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_end_r) |=> (state_r == LexReset))
    else $error("lexer state not cleared after end mark");

endmodule
